// ----- hw/rtl/mpbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mpbf_pkg
// Shared types and constants of the byte pipe table: item layouts, operation
// kinds, status codes, the classified command and the back-end states.
// ----------------------------------------------------------------------------
package mpbf_pkg;

	localparam int PIPE_COUNT_DEF  = 8;
	localparam int PIPE_DEPTH_DEF  = 2048;
	localparam int HANDLE_BASE_DEF = 48;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_CLOSE  = 2'd3
	} kind_e;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_NOSLOT = 3'd1,
		ST_FULL   = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_EOF    = 3'd4
	} status_e;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] handle;
		logic [7:0] byte_in;
	} req_item_t;

	typedef struct packed {
		status_e    status;
		logic [7:0] byte_out;
		logic [7:0] read_handle;
		logic [7:0] write_handle;
	} rsp_item_t;

	// One decoded operation, as handed from the front end to the back end.
	typedef struct packed {
		logic       op_create;
		logic       op_write;
		logic       op_read;
		logic       op_close;
		logic [7:0] handle;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_LOOK = 2'd1,
		B_EXEC = 2'd2,
		B_RESP = 2'd3
	} back_state_e;

endpackage

// ----- hw/rtl/multi_pipe_byte_fifo_table_core.sv -----
// ----------------------------------------------------------------------------
// multi_pipe_byte_fifo_table_core
// Table of byte pipes with create, write, read and close operations.
// ----------------------------------------------------------------------------
// In the back end each request item is first taken from the queue, then its
// handle is looked up while the counter memory is read, then the counters are
// updated and the byte store accessed, and finally the result is placed in the
// output register; a new item is taken only after that. The input register
// and a two-entry command queue let up to three further items be accepted
// while one is being executed or while a result waits to be taken. The byte
// store has no reset: a pipe's counters are cleared on create, and only bytes
// that were written are ever read back.
// There is no clearing pass after reset.
module multi_pipe_byte_fifo_table_core #(
	parameter int PIPE_COUNT  = mpbf_pkg::PIPE_COUNT_DEF,
	parameter int PIPE_DEPTH  = mpbf_pkg::PIPE_DEPTH_DEF,
	parameter int HANDLE_BASE = mpbf_pkg::HANDLE_BASE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mpbf_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mpbf_pkg::rsp_item_t rsp
);
	import mpbf_pkg::*;

	// Decoded commands from the front end into the queue.
	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;

	// Commands from the queue into the back end.
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	// The front end registers each item and decodes its kind.
	mpbf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// The queue lets the front end keep accepting while the back end works.
	mpbf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	// The back end owns the slot table, counters and byte store.
	mpbf_back #(
		.PIPE_COUNT  (PIPE_COUNT),
		.PIPE_DEPTH  (PIPE_DEPTH),
		.HANDLE_BASE (HANDLE_BASE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- hw/rtl/mpbf_front.sv -----
// ----------------------------------------------------------------------------
// mpbf_front
// Input register: accepts request items and decodes the kind into a command.
// ----------------------------------------------------------------------------
module mpbf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  mpbf_pkg::req_item_t req,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output mpbf_pkg::cmd_t     cmd
);
	import mpbf_pkg::*;

	logic cmd_valid_q;
	cmd_t cmd_q;
	cmd_t cmd_d;

	assign req_ready = !cmd_valid_q || cmd_ready;
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	always_comb begin
		cmd_d = '0;
		cmd_d.handle = req.handle;
		cmd_d.data   = req.byte_in;
		unique case (kind_e'(req.kind))
			KIND_CREATE: begin
				cmd_d.op_create = 1'b1;
			end
			KIND_WRITE: begin
				cmd_d.op_write = 1'b1;
			end
			KIND_READ: begin
				cmd_d.op_read = 1'b1;
			end
			KIND_CLOSE: begin
				cmd_d.op_close = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (req_ready) begin
			cmd_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= cmd_d;
		end
	end

endmodule

// ----- hw/rtl/mpbf_queue.sv -----
// ----------------------------------------------------------------------------
// mpbf_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mpbf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mpbf_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mpbf_pkg::cmd_t pop_cmd
);
	import mpbf_pkg::*;

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- hw/rtl/mpbf_back.sv -----
// ----------------------------------------------------------------------------
// mpbf_back
// Executes commands against the pipe table: handle lookup, counter update,
// byte store access and the result register.
// ----------------------------------------------------------------------------
module mpbf_back #(
	parameter int PIPE_COUNT  = mpbf_pkg::PIPE_COUNT_DEF,
	parameter int PIPE_DEPTH  = mpbf_pkg::PIPE_DEPTH_DEF,
	parameter int HANDLE_BASE = mpbf_pkg::HANDLE_BASE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  mpbf_pkg::cmd_t      cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mpbf_pkg::rsp_item_t rsp
);
	import mpbf_pkg::*;

	localparam int SLOT_W = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
	localparam int PTR_W  = $clog2(PIPE_DEPTH);
	localparam int CNT_W  = $clog2(PIPE_DEPTH + 1);
	localparam int POS_W  = PTR_W + 1;
	localparam int CTR_W  = CNT_W + PTR_W;
	localparam int ADDR_W = $clog2(PIPE_COUNT * PIPE_DEPTH);
	localparam int MEM_D  = PIPE_COUNT * PIPE_DEPTH;

	back_state_e state_q, state_d;
	logic        rsp_load;

	cmd_t                  cmd_q;
	logic [PIPE_COUNT-1:0] in_use_q;
	logic [PIPE_COUNT-1:0] rd_open_q;
	logic [PIPE_COUNT-1:0] wr_open_q;
	logic [PIPE_COUNT-1:0] rd_eq;
	logic [PIPE_COUNT-1:0] wr_eq;

	// Counter memory, one word {fill, read pointer} per slot, and the byte store.
	logic [CTR_W-1:0] ctr_mem [PIPE_COUNT];
	logic [CTR_W-1:0] ctr_rd_q;
	logic [7:0]       byte_mem [MEM_D];
	logic [7:0]       byte_rd_q;

	logic [SLOT_W-1:0] look_slot;
	logic              look_hit;
	logic              look_rd;
	logic              look_wr;

	logic [SLOT_W-1:0] slot_s2;
	logic              hit_s2;
	logic              rd_match_s2;
	logic              wr_match_s2;

	status_e    status_s3;
	logic [7:0] rh_s3;
	logic [7:0] wh_s3;
	logic       read_ok_s3;

	rsp_item_t rsp_q;
	logic      rsp_valid_q;

	// Execute-stage signals.
	logic [CNT_W-1:0]  fill_cur;
	logic [PTR_W-1:0]  rptr_cur;
	logic [POS_W-1:0]  pos_sum;
	logic [PTR_W-1:0]  wr_pos;
	logic [ADDR_W-1:0] slot_base;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic              mem_re;
	logic              ctr_we;
	logic [CTR_W-1:0]  ctr_wdata;
	logic              set_slot;
	logic              clr_rd;
	logic              clr_wr;
	status_e           ex_status;
	logic [8:0]        ex_rh9;
	logic [8:0]        ex_wh9;
	logic              ex_read_ok;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = B_LOOK;
				end
			end
			B_LOOK: begin
				state_d = B_EXEC;
			end
			B_EXEC: begin
				state_d = B_RESP;
			end
			B_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_q <= cmd;
		end
	end

	// ---------------- lookup ----------------
	always_comb begin
		for (int i = 0; i < PIPE_COUNT; i++) begin
			rd_eq[i] = in_use_q[i] && rd_open_q[i] &&
				({1'b0, cmd_q.handle} == 9'(HANDLE_BASE + 2 * i));
			wr_eq[i] = in_use_q[i] && wr_open_q[i] &&
				({1'b0, cmd_q.handle} == 9'(HANDLE_BASE + 2 * i + 1));
		end
	end

	// Lowest free slot for a create, lowest open match otherwise.
	always_comb begin
		look_slot = '0;
		look_hit  = 1'b0;
		look_rd   = 1'b0;
		look_wr   = 1'b0;
		for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
			if (cmd_q.op_create) begin
				if (!in_use_q[i]) begin
					look_slot = SLOT_W'(i);
					look_hit  = 1'b1;
				end
			end else if (rd_eq[i] || wr_eq[i]) begin
				look_slot = SLOT_W'(i);
				look_hit  = 1'b1;
				look_rd   = rd_eq[i];
				look_wr   = wr_eq[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_LOOK) begin
			slot_s2     <= look_slot;
			hit_s2      <= look_hit;
			rd_match_s2 <= look_rd;
			wr_match_s2 <= look_wr;
		end
	end

	// ---------------- execute ----------------
	assign fill_cur  = ctr_rd_q[CTR_W-1:PTR_W];
	assign rptr_cur  = ctr_rd_q[PTR_W-1:0];
	assign pos_sum   = POS_W'(rptr_cur) + POS_W'(fill_cur);
	assign slot_base = ADDR_W'(slot_s2 * PIPE_DEPTH);

	always_comb begin
		if (pos_sum >= POS_W'(PIPE_DEPTH)) begin
			wr_pos = PTR_W'(pos_sum - POS_W'(PIPE_DEPTH));
		end else begin
			wr_pos = pos_sum[PTR_W-1:0];
		end
	end

	always_comb begin
		ex_status  = ST_OK;
		ex_rh9     = '0;
		ex_wh9     = '0;
		ex_read_ok = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = slot_base + ADDR_W'(wr_pos);
		ctr_we     = 1'b0;
		ctr_wdata  = '0;
		set_slot   = 1'b0;
		clr_rd     = 1'b0;
		clr_wr     = 1'b0;
		if (state_q == B_EXEC) begin
			if (!hit_s2) begin
				ex_status = ST_NOSLOT;
			end else begin
				priority if (cmd_q.op_create) begin
					set_slot = 1'b1;
					ctr_we   = 1'b1;
					ex_rh9   = 9'(HANDLE_BASE) + 9'({slot_s2, 1'b0});
					ex_wh9   = ex_rh9 + 9'd1;
				end else if (cmd_q.op_write) begin
					if (fill_cur == CNT_W'(PIPE_DEPTH)) begin
						ex_status = ST_FULL;
					end else begin
						mem_we    = 1'b1;
						ctr_we    = 1'b1;
						ctr_wdata = {fill_cur + 1'b1, rptr_cur};
					end
				end else if (cmd_q.op_read) begin
					if (fill_cur == '0) begin
						ex_status = wr_open_q[slot_s2] ? ST_EMPTY : ST_EOF;
					end else begin
						mem_re     = 1'b1;
						ex_read_ok = 1'b1;
						mem_addr   = slot_base + ADDR_W'(rptr_cur);
						ctr_we     = 1'b1;
						ctr_wdata[CTR_W-1:PTR_W] = fill_cur - 1'b1;
						ctr_wdata[PTR_W-1:0] = (rptr_cur == PTR_W'(PIPE_DEPTH - 1)) ?
							'0 : rptr_cur + 1'b1;
					end
				end else begin
					clr_rd = rd_match_s2;
					clr_wr = wr_match_s2;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			rd_open_q <= '0;
			wr_open_q <= '0;
		end else if (set_slot) begin
			in_use_q[slot_s2]  <= 1'b1;
			rd_open_q[slot_s2] <= 1'b1;
			wr_open_q[slot_s2] <= 1'b1;
		end else if (clr_rd || clr_wr) begin
			if (clr_rd) begin
				rd_open_q[slot_s2] <= 1'b0;
			end
			if (clr_wr) begin
				wr_open_q[slot_s2] <= 1'b0;
			end
			if ((!rd_open_q[slot_s2] || clr_rd) && (!wr_open_q[slot_s2] || clr_wr)) begin
				in_use_q[slot_s2] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctr_we) begin
			ctr_mem[slot_s2] <= ctr_wdata;
		end
		if (state_q == B_LOOK) begin
			ctr_rd_q <= ctr_mem[look_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			byte_mem[mem_addr] <= cmd_q.data;
		end
		if (mem_re) begin
			byte_rd_q <= byte_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_EXEC) begin
			status_s3  <= ex_status;
			rh_s3      <= ex_rh9[7:0];
			wh_s3      <= ex_wh9[7:0];
			read_ok_s3 <= ex_read_ok;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status       <= status_s3;
			rsp_q.byte_out     <= read_ok_s3 ? byte_rd_q : 8'd0;
			rsp_q.read_handle  <= rh_s3;
			rsp_q.write_handle <= wh_s3;
		end
	end

`ifndef SYNTHESIS
	a_slot_open_ends: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q == (rd_open_q | wr_open_q))
		else $error("slot in use without an open end, or open end on a free slot");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EXEC && hit_s2 && !cmd_q.op_create) |-> fill_cur <= CNT_W'(PIPE_DEPTH))
		else $error("pipe fill count beyond its depth");

	a_pop_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> state_q == B_LOOK)
		else $error("accepted command did not enter lookup");

	a_exec_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_EXEC |=> state_q == B_RESP)
		else $error("execute step not followed by result step");
`endif

endmodule

// ----- verif/multi_pipe_byte_fifo_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// multi_pipe_byte_fifo_table_core_tb
// Self-checking testbench for the byte pipe table. A behavioral copy of the
// pipe table predicts the result of every accepted request item. A checker
// compares each result item field by field, in order, against those
// predictions. The tests cover directed handle and status cases, one pipe
// streamed through in order, a long output stall and random traffic.
// ----------------------------------------------------------------------------
module multi_pipe_byte_fifo_table_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mpbf_pkg::*;

	localparam int N_PIPES         = PIPE_COUNT_DEF;
	localparam int RING_BYTES      = PIPE_DEPTH_DEF;
	localparam int STREAM_BYTES    = 200;
	localparam int RANDOM_ITEMS    = 360;
	localparam int RSP_HOLD_CYCLES = 400;
	localparam int IDLE_PERCENT    = 35;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	// Shadow copy of the pipe table, updated as each request item is accepted.
	logic       pipe_busy   [N_PIPES];
	logic       reader_live [N_PIPES];
	logic       writer_live [N_PIPES];
	int         pipe_fill   [N_PIPES];
	int         pipe_head   [N_PIPES];
	logic [7:0] pipe_bytes  [N_PIPES][RING_BYTES];

	// Predicted results in the order the block must deliver them.
	rsp_item_t pending_rsps[$];

	int  errors;
	int  items_sent;
	int  results_seen;
	int  status_tally[5];
	// Random idling on both channels is switched off for some stretches.
	logic idle_on;
	// Set by a test to make the result side refuse items for a long while.
	logic hold_rsp;

	multi_pipe_byte_fifo_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// The watchdog: far beyond the slowest legal run of every test.
	initial begin
		#4_000_000;
		$display("multi_pipe_byte_fifo_table_core test failed");
		$finish;
	end

	function automatic logic [7:0] read_handle_of(input int slot);
		return 8'(HANDLE_BASE_DEF + 2 * slot);
	endfunction

	// Applies one request item to the shadow table and returns the result
	// item the block has to produce for it.
	function automatic rsp_item_t pipe_table_apply(input req_item_t item);
		rsp_item_t r;
		int        slot;
		int        pos;
		r.status       = ST_OK;
		r.byte_out     = 8'h00;
		r.read_handle  = 8'h00;
		r.write_handle = 8'h00;
		slot           = N_PIPES;
		if (item.kind == KIND_CREATE) begin
			// Lowest free slot wins.
			for (int s = N_PIPES - 1; s >= 0; s--) begin
				if (!pipe_busy[s])
					slot = s;
			end
			if (slot == N_PIPES) begin
				r.status = ST_NOSLOT;
			end else begin
				pipe_busy[slot]   = 1'b1;
				reader_live[slot] = 1'b1;
				writer_live[slot] = 1'b1;
				pipe_fill[slot]   = 0;
				pipe_head[slot]   = 0;
				r.read_handle     = read_handle_of(slot);
				r.write_handle    = read_handle_of(slot) + 8'd1;
			end
		end else begin
			// A handle only matches an end that is still open.
			for (int s = N_PIPES - 1; s >= 0; s--) begin
				if (pipe_busy[s] &&
						((reader_live[s] && read_handle_of(s) == item.handle) ||
						(writer_live[s] && read_handle_of(s) + 8'd1 == item.handle)))
					slot = s;
			end
			if (slot == N_PIPES) begin
				r.status = ST_NOSLOT;
			end else if (item.kind == KIND_WRITE) begin
				if (pipe_fill[slot] >= RING_BYTES) begin
					r.status = ST_FULL;
				end else begin
					pos = (pipe_head[slot] + pipe_fill[slot]) % RING_BYTES;
					pipe_bytes[slot][pos] = item.byte_in;
					pipe_fill[slot]++;
				end
			end else if (item.kind == KIND_READ) begin
				if (pipe_fill[slot] == 0) begin
					r.status = writer_live[slot] ? ST_EMPTY : ST_EOF;
				end else begin
					r.byte_out      = pipe_bytes[slot][pipe_head[slot]];
					pipe_head[slot] = (pipe_head[slot] + 1) % RING_BYTES;
					pipe_fill[slot]--;
				end
			end else begin
				if (reader_live[slot] && read_handle_of(slot) == item.handle)
					reader_live[slot] = 1'b0;
				if (writer_live[slot] && read_handle_of(slot) + 8'd1 == item.handle)
					writer_live[slot] = 1'b0;
				if (!reader_live[slot] && !writer_live[slot])
					pipe_busy[slot] = 1'b0;
			end
		end
		return r;
	endfunction

	// Picks one request item of random traffic. Most items act on a pipe end
	// that is open, so that pipes get filled, drained and closed; the rest
	// are raw noise over every kind, handle and byte.
	function automatic req_item_t random_traffic_item();
		req_item_t   item;
		logic [7:0]  live[$];
		int unsigned roll;
		for (int s = 0; s < N_PIPES; s++) begin
			if (pipe_busy[s] && reader_live[s])
				live.push_back(read_handle_of(s));
			if (pipe_busy[s] && writer_live[s])
				live.push_back(read_handle_of(s) + 8'd1);
		end
		roll         = $urandom_range(99);
		item.byte_in = 8'($urandom_range(255));
		if (live.size() == 0)
			item.handle = 8'($urandom_range(255));
		else
			item.handle = live[$urandom_range(live.size() - 1)];
		if (roll < 8) begin
			item.kind = KIND_CREATE;
		end else if (roll < 48) begin
			item.kind = KIND_WRITE;
		end else if (roll < 83) begin
			item.kind = KIND_READ;
		end else if (roll < 90) begin
			item.kind = KIND_CLOSE;
		end else begin
			item.kind   = 2'($urandom_range(3));
			item.handle = 8'($urandom_range(255));
		end
		return item;
	endfunction

	// Offers one request item and holds it until the block takes it. The
	// valid line is only lowered during an idle gap, never at the edge where
	// it is raised again for the next item.
	task automatic issue_req(input kind_e k, input logic [7:0] h, input logic [7:0] b);
		req_item_t item;
		rsp_item_t want;
		item.kind    = k;
		item.handle  = h;
		item.byte_in = b;
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		want = pipe_table_apply(item);
		pending_rsps.push_back(want);
		status_tally[want.status]++;
		items_sent++;
	endtask

	// Stops offering items and waits until every predicted result is in.
	task automatic drain_pending();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsps.size() != 0)
			@(posedge clk);
	endtask

	// Unknown handles before anything exists, then one pipe through each
	// end, write and read through the opposite end, end of file after the
	// writer closes, and the table running out of slots.
	task automatic test_directed_ops();
		logic [7:0] rd_h;
		rd_h = read_handle_of(0);
		issue_req(KIND_READ, rd_h, 8'h00);
		issue_req(KIND_CLOSE, 8'hFF, 8'hFF);
		issue_req(KIND_CREATE, 8'h00, 8'h00);
		issue_req(KIND_READ, rd_h, 8'h00);
		issue_req(KIND_WRITE, rd_h + 8'd1, 8'h00);
		// A write through the read end is allowed.
		issue_req(KIND_WRITE, rd_h, 8'hFF);
		// So is a read through the write end.
		issue_req(KIND_READ, rd_h + 8'd1, 8'h00);
		issue_req(KIND_READ, rd_h, 8'h00);
		issue_req(KIND_WRITE, rd_h + 8'd1, 8'hA5);
		issue_req(KIND_CLOSE, rd_h + 8'd1, 8'h00);
		issue_req(KIND_READ, rd_h, 8'h00);
		// Drained with the writer gone: end of file, and the closed write
		// handle no longer matches anything.
		issue_req(KIND_READ, rd_h, 8'h00);
		issue_req(KIND_WRITE, rd_h + 8'd1, 8'h5A);
		issue_req(KIND_CLOSE, rd_h, 8'h00);
		// Nine creates on an empty table: the last finds no free slot.
		for (int n = 0; n <= N_PIPES; n++)
			issue_req(KIND_CREATE, 8'($urandom_range(255)), 8'($urandom_range(255)));
		// Freeing slot one makes it the lowest free slot again.
		issue_req(KIND_CLOSE, read_handle_of(1) + 8'd1, 8'h00);
		issue_req(KIND_CLOSE, read_handle_of(1), 8'h00);
		issue_req(KIND_CREATE, 8'h00, 8'h00);
		issue_req(KIND_WRITE, 8'h00, 8'h3C);
	endtask

	// One pipe takes a long run of bytes and hands them back in order, then
	// reports empty and, once the writer has closed, end of file.
	task automatic test_pipe_stream();
		logic [7:0] rd_h;
		// Close every open end so the next create lands in slot zero.
		for (int s = 0; s < N_PIPES; s++) begin
			if (pipe_busy[s] && reader_live[s])
				issue_req(KIND_CLOSE, read_handle_of(s), 8'h00);
			if (pipe_busy[s] && writer_live[s])
				issue_req(KIND_CLOSE, read_handle_of(s) + 8'd1, 8'h00);
		end
		rd_h = read_handle_of(0);
		issue_req(KIND_CREATE, 8'h00, 8'h00);
		// The fill runs without idling on either side.
		idle_on = 1'b0;
		for (int n = 0; n < STREAM_BYTES; n++)
			issue_req(KIND_WRITE, rd_h + 8'd1, 8'($urandom_range(255)));
		idle_on = 1'b1;
		for (int n = 0; n < STREAM_BYTES; n++)
			issue_req(KIND_READ, rd_h, 8'h00);
		issue_req(KIND_READ, rd_h, 8'h00);
		issue_req(KIND_CLOSE, rd_h + 8'd1, 8'h00);
		issue_req(KIND_READ, rd_h, 8'h00);
		issue_req(KIND_CLOSE, rd_h, 8'h00);
	endtask

	// The result side refuses items for a long while as the sender keeps
	// offering, so the internal queue fills and the request side stalls.
	// Then the sender waits until every result has come out.
	task automatic test_backpressure();
		req_item_t item;
		hold_rsp = 1'b1;
		for (int n = 0; n < 40; n++) begin
			item = random_traffic_item();
			issue_req(kind_e'(item.kind), item.handle, item.byte_in);
		end
		drain_pending();
	endtask

	// Random traffic with a long stretch in the middle without idling.
	task automatic test_random_traffic();
		req_item_t item;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = !(n >= 120 && n < 280);
			item    = random_traffic_item();
			issue_req(kind_e'(item.kind), item.handle, item.byte_in);
		end
		idle_on = 1'b1;
	endtask

	// The result side: random refusals, or a long hold when a test asks for
	// it. The hold is counted here so the sender can keep pushing meanwhile.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES)
					@(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				rsp_ready <= !idle_on || $urandom_range(99) >= IDLE_PERCENT;
			end
		end
	end

	// Every accepted result item is matched against the oldest prediction.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			if (pending_rsps.size() == 0) begin
				$error("result item with no prediction pending: %p", rsp);
				errors++;
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.byte_out !== want.byte_out) begin
					$error("byte_out: expected %0h, got %0h", want.byte_out, rsp.byte_out);
					errors++;
				end
				if (rsp.read_handle !== want.read_handle) begin
					$error("read_handle: expected %0d, got %0d",
						want.read_handle, rsp.read_handle);
					errors++;
				end
				if (rsp.write_handle !== want.write_handle) begin
					$error("write_handle: expected %0d, got %0d",
						want.write_handle, rsp.write_handle);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		rsp_ready    = 1'b0;
		idle_on      = 1'b1;
		hold_rsp     = 1'b0;
		errors       = 0;
		items_sent   = 0;
		results_seen = 0;
		for (int s = 0; s < 5; s++)
			status_tally[s] = 0;
		for (int s = 0; s < N_PIPES; s++) begin
			pipe_busy[s]   = 1'b0;
			reader_live[s] = 1'b0;
			writer_live[s] = 1'b0;
			pipe_fill[s]   = 0;
			pipe_head[s]   = 0;
		end
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_pipe_stream();
		test_backpressure();
		test_random_traffic();

		drain_pending();
		// Wait on after the last result before the summary is printed.
		repeat (16)
			@(posedge clk);
		$display("Ran %0d request items and checked %0d result items.",
			items_sent, results_seen);
		$display("Statuses: ok %0d, no slot %0d, full %0d, empty %0d, end of file %0d.",
			status_tally[ST_OK], status_tally[ST_NOSLOT], status_tally[ST_FULL],
			status_tally[ST_EMPTY], status_tally[ST_EOF]);
		if (errors == 0 && pending_rsps.size() == 0) begin
			$display("multi_pipe_byte_fifo_table_core test passed");
		end else begin
			$display("multi_pipe_byte_fifo_table_core test failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/mpbf_pkg.sv
hw/rtl/mpbf_front.sv
hw/rtl/mpbf_queue.sv
hw/rtl/mpbf_back.sv
hw/rtl/multi_pipe_byte_fifo_table_core.sv
verif/multi_pipe_byte_fifo_table_core_tb.sv
